// ===== rtl/core/cramer_3x3_solver_assert.svh =====
// Assertion macros used by the solver top level.
`ifndef CRAMER_3X3_SOLVER_ASSERT_SVH
`define CRAMER_3X3_SOLVER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define C3S_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c3s assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define C3S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c3s assertion failed");

`endif

// ===== rtl/core/c3s_pkg.sv =====
// Shared widths, latencies and types of the 3x3 solver.
package c3s_pkg;

  localparam int CW        = 16;            // coefficient width, Q8.8
  localparam int XW        = 2 * CW + 1;    // cross-product component
  localparam int TW        = 3 * CW + 1;    // one dot-product term
  localparam int SW        = TW + 2;        // sum of three terms
  localparam int DW        = 50;            // determinant width, Q24.24
  localparam int QW        = 32;            // solution width, Q16.16
  localparam int SOL_FRAC  = 16;
  localparam int DIV_STEPS = QW - 1;        // quotient bits below the sign
  localparam int HI_SHIFT  = QW - 1 - SOL_FRAC;
  localparam int DET_LAT   = 3;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int LAT       = DET_LAT + DIV_LAT;
  localparam int IN_W      = 12 * CW;
  localparam int OUT_DW    = 152;           // 3*QW + DW = 146, padded to bytes

  typedef logic [11:0][CW-1:0] sys_t;       // row-major, four fields per row
  typedef logic [3:0][DW-1:0]  det_vec_t;   // main, x, y, z

  typedef struct packed {
    logic                sing;
    logic                neg;
    logic                sat;
    logic [DW-1:0]       d;
    logic [DW-1:0]       r;
    logic [HI_SHIFT-1:0] nlo;
    logic [DIV_STEPS-1:0] q;
  } div_t;

endpackage

// ===== rtl/core/c3s_det.sv =====
// Three-stage pipeline forming the main and the three replaced determinants.
module c3s_det (
  input  logic              clk,
  input  logic              en,
  input  c3s_pkg::sys_t     sys,
  output c3s_pkg::det_vec_t dets
);

  // column vectors: x, y, z coefficients and right-hand side
  logic signed [c3s_pkg::CW-1:0] cx [3];
  logic signed [c3s_pkg::CW-1:0] cy [3];
  logic signed [c3s_pkg::CW-1:0] cz [3];
  logic signed [c3s_pkg::CW-1:0] cr [3];

  logic signed [c3s_pkg::XW-1:0] yz_nxt [3], rz_nxt [3], yr_nxt [3];
  logic signed [c3s_pkg::XW-1:0] yz_r [3], rz_r [3], yr_r [3];
  logic signed [c3s_pkg::CW-1:0] x1_r [3], r1_r [3];

  logic signed [c3s_pkg::TW-1:0] t_nxt [4][3];
  logic signed [c3s_pkg::TW-1:0] t_r [4][3];

  logic signed [c3s_pkg::SW-1:0] s_nxt [4];
  c3s_pkg::det_vec_t             det_r;

  function automatic logic signed [c3s_pkg::XW-1:0] mdiff(
    input logic signed [c3s_pkg::CW-1:0] a, input logic signed [c3s_pkg::CW-1:0] b,
    input logic signed [c3s_pkg::CW-1:0] c, input logic signed [c3s_pkg::CW-1:0] d);
    logic signed [c3s_pkg::XW-1:0] pa;
    logic signed [c3s_pkg::XW-1:0] pb;
    pa = a * b;
    pb = c * d;
    return pa - pb;
  endfunction

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cx[j] = $signed(sys[j*4]);
      cy[j] = $signed(sys[j*4+1]);
      cz[j] = $signed(sys[j*4+2]);
      cr[j] = $signed(sys[j*4+3]);
    end
    // b x c = (b1c2-b2c1, b2c0-b0c2, b0c1-b1c0)
    yz_nxt[0] = mdiff(cy[1], cz[2], cy[2], cz[1]);
    yz_nxt[1] = mdiff(cy[2], cz[0], cy[0], cz[2]);
    yz_nxt[2] = mdiff(cy[0], cz[1], cy[1], cz[0]);
    rz_nxt[0] = mdiff(cr[1], cz[2], cr[2], cz[1]);
    rz_nxt[1] = mdiff(cr[2], cz[0], cr[0], cz[2]);
    rz_nxt[2] = mdiff(cr[0], cz[1], cr[1], cz[0]);
    yr_nxt[0] = mdiff(cy[1], cr[2], cy[2], cr[1]);
    yr_nxt[1] = mdiff(cy[2], cr[0], cy[0], cr[2]);
    yr_nxt[2] = mdiff(cy[0], cr[1], cy[1], cr[0]);
  end

  // det(A,B,C) = A . (B x C)
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t_nxt[0][j] = x1_r[j] * yz_r[j];
      t_nxt[1][j] = r1_r[j] * yz_r[j];
      t_nxt[2][j] = x1_r[j] * rz_r[j];
      t_nxt[3][j] = x1_r[j] * yr_r[j];
    end
    for (int k = 0; k < 4; k++) begin
      s_nxt[k] = c3s_pkg::SW'(t_r[k][0]) + c3s_pkg::SW'(t_r[k][1])
               + c3s_pkg::SW'(t_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        yz_r[j] <= yz_nxt[j];
        rz_r[j] <= rz_nxt[j];
        yr_r[j] <= yr_nxt[j];
        x1_r[j] <= cx[j];
        r1_r[j] <= cr[j];
      end
      t_r <= t_nxt;
      for (int k = 0; k < 4; k++) begin
        det_r[k] <= s_nxt[k][c3s_pkg::DW-1:0];
      end
    end
  end

  assign dets = det_r;

endmodule

// ===== rtl/core/c3s_div.sv =====
// Pipelined restoring divider: signed Q24.24 ratio to saturated Q16.16, one bit a stage.
module c3s_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [c3s_pkg::DW-1:0]   num,
  input  logic [c3s_pkg::DW-1:0]   den,
  output logic [c3s_pkg::QW-1:0]   quo,
  output logic                     sat
);

  c3s_pkg::div_t st_nxt [c3s_pkg::DIV_STEPS+1];
  c3s_pkg::div_t st_r   [c3s_pkg::DIV_STEPS+1];
  logic [c3s_pkg::QW-1:0] quo_r, quo_nxt;
  logic                   sat_r, sat_nxt;

  logic [c3s_pkg::DW-1:0] n_mag, d_mag;

  // prep: magnitudes, sign, overflow test (|n| >= |d| * 2^15), first remainder;
  // then one quotient bit per stage
  always_comb begin
    logic [c3s_pkg::DW:0] rs;
    logic                 bitv;
    int                   i;
    n_mag = num[c3s_pkg::DW-1] ? (~num + 1'b1) : num;
    d_mag = den[c3s_pkg::DW-1] ? (~den + 1'b1) : den;
    st_nxt[0].sing = (den == '0);
    st_nxt[0].neg  = (num[c3s_pkg::DW-1] != den[c3s_pkg::DW-1]) && (num != '0);
    st_nxt[0].sat  = {{c3s_pkg::HI_SHIFT{1'b0}}, n_mag}
                     >= {d_mag, {c3s_pkg::HI_SHIFT{1'b0}}};
    st_nxt[0].d    = d_mag;
    st_nxt[0].r    = n_mag >> c3s_pkg::HI_SHIFT;
    st_nxt[0].nlo  = n_mag[c3s_pkg::HI_SHIFT-1:0];
    st_nxt[0].q    = '0;
    for (int k = 0; k < c3s_pkg::DIV_STEPS; k++) begin
      i = c3s_pkg::DIV_STEPS - 1 - k;
      st_nxt[k+1] = st_r[k];
      bitv = 1'b0;
      if (i >= c3s_pkg::SOL_FRAC) begin
        bitv = st_r[k].nlo[i-c3s_pkg::SOL_FRAC];
      end
      rs = {st_r[k].r, bitv};
      if (rs >= {1'b0, st_r[k].d}) begin
        rs = rs - {1'b0, st_r[k].d};
        st_nxt[k+1].q[i] = 1'b1;
      end
      st_nxt[k+1].r = rs[c3s_pkg::DW-1:0];
    end
  end

  // apply limit and sign; a zero divisor yields zero
  always_comb begin
    logic [c3s_pkg::QW-1:0] lim;
    logic [c3s_pkg::QW-1:0] qmag;
    c3s_pkg::div_t          fin;
    fin  = st_r[c3s_pkg::DIV_STEPS];
    lim  = fin.neg ? {1'b1, {(c3s_pkg::QW-1){1'b0}}} : {1'b0, {(c3s_pkg::QW-1){1'b1}}};
    qmag = fin.sat ? lim : {1'b0, fin.q};
    if (fin.sing) begin
      quo_nxt = '0;
    end else if (fin.neg) begin
      quo_nxt = ~qmag + 1'b1;
    end else begin
      quo_nxt = qmag;
    end
    sat_nxt = fin.sat && !fin.sing;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= c3s_pkg::DIV_STEPS; k++) begin
        st_r[k] <= st_nxt[k];
      end
      quo_r <= quo_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule

// ===== rtl/core/cramer_3x3_solver.sv =====
// Top level of the pipelined 3x3 Cramer's-rule solver.
// Solves A*[x y z] = rhs for one system per transaction. Inputs are twelve signed
// Q8.8 values; the main determinant and the three column-replaced determinants
// are formed exactly in Q24.24 (cross products, then dot products, then sums:
// three stages), then each replaced determinant is divided by the main one in a
// restoring divider that resolves one quotient bit per stage (31 stages plus a
// prep and a finish stage). Solutions are Q16.16, truncated toward zero and
// clipped to the 32-bit range; saturated flags any clip. A zero determinant
// gives singular = 1 and all-zero solutions. Throughput is one transaction per
// clock while the output is not stalled. The whole pipeline advances together
// whenever the output stage is empty or being taken, so a stall at the output
// holds every stage and loses nothing.
module cramer_3x3_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // row0_x, row0_y, row0_z, row0_rhs, row1_x .. row1_rhs, row2_x .. row2_rhs
  input  logic [c3s_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // sol_x, sol_y, sol_z, main_det, zero pad
  output logic [c3s_pkg::OUT_DW-1:0]    out_tdata,
  // singular, saturated
  output logic [1:0]                    out_tuser
);

  logic                   en;
  logic                   vld_r [c3s_pkg::LAT];
  c3s_pkg::det_vec_t      dets;
  logic [c3s_pkg::DW-1:0] det_r  [c3s_pkg::DIV_LAT];
  logic                   sing_r [c3s_pkg::DIV_LAT];
  logic [c3s_pkg::QW-1:0] sol [3];
  logic                   sat [3];

  // global advance: last stage empty or its transaction taken
  assign en        = !vld_r[c3s_pkg::LAT-1] || out_tready;
  assign in_tready = en;

  c3s_det u_det (
    .clk  (clk),
    .en   (en),
    .sys  (c3s_pkg::sys_t'(in_tdata)),
    .dets (dets)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    c3s_div u_div (
      .clk (clk),
      .en  (en),
      .num (dets[g+1]),
      .den (dets[0]),
      .quo (sol[g]),
      .sat (sat[g])
    );
  end

  // valid bits ride alongside the data stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < c3s_pkg::LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < c3s_pkg::LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // main determinant and singular flag delayed to match the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      det_r[0]  <= dets[0];
      sing_r[0] <= (dets[0] == '0);
      for (int k = 1; k < c3s_pkg::DIV_LAT; k++) begin
        det_r[k]  <= det_r[k-1];
        sing_r[k] <= sing_r[k-1];
      end
    end
  end

  assign out_tvalid = vld_r[c3s_pkg::LAT-1];
  assign out_tdata  = {{(c3s_pkg::OUT_DW - 3*c3s_pkg::QW - c3s_pkg::DW){1'b0}},
                       det_r[c3s_pkg::DIV_LAT-1], sol[2], sol[1], sol[0]};
  assign out_tuser  = {sat[0] | sat[1] | sat[2], sing_r[c3s_pkg::DIV_LAT-1]};

`include "cramer_3x3_solver_assert.svh"

  // singular result carries zero solutions and no clip
  `C3S_ASSERT_NOW(a_sing_zero, out_tvalid && out_tuser[0],
    out_tdata[95:0] == 96'd0 && !out_tuser[1])
  // singular flag agrees with the delayed determinant
  `C3S_ASSERT_NOW(a_sing_det, out_tvalid,
    out_tuser[0] == (out_tdata[145:96] == 50'd0))
  // a clip leaves at least one solution at a range limit
  `C3S_ASSERT_NOW(a_sat_limit, out_tvalid && out_tuser[1],
    out_tdata[31:0] == 32'h7fffffff || out_tdata[31:0] == 32'h80000000 ||
    out_tdata[63:32] == 32'h7fffffff || out_tdata[63:32] == 32'h80000000 ||
    out_tdata[95:64] == 32'h7fffffff || out_tdata[95:64] == 32'h80000000)
  // a held output keeps its transaction while the pipeline is frozen
  `C3S_ASSERT_NEXT(a_hold_flags, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tuser) && $stable(out_tdata))
  // a held output blocks the input
  `C3S_ASSERT_NOW(a_hold_input, out_tvalid && !out_tready, !in_tready)

endmodule

// ===== test/tb_top.sv =====
// Testbench for cramer_3x3_solver: a queue-fed stream driver, a checking monitor and a predictor.
`timescale 1ns / 1ps

module tb_top;

  // One expected result: solutions in Q16.16, exact determinant in Q24.24, the two flags.
  typedef struct {
    logic [c3s_pkg::QW-1:0] x;
    logic [c3s_pkg::QW-1:0] y;
    logic [c3s_pkg::QW-1:0] z;
    logic [c3s_pkg::DW-1:0] det;
    logic                   singular;
    logic                   saturated;
  } solution_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [c3s_pkg::IN_W-1:0]     in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [c3s_pkg::OUT_DW-1:0]   out_tdata;
  logic [1:0]                   out_tuser;

  c3s_pkg::sys_t pending_systems[$];  // systems not yet offered to the block
  solution_t expected_solutions[$];  // one entry per accepted transaction, oldest first
  c3s_pkg::sys_t cur_sys;
  int        gap_cnt;
  int        stall_cnt;
  int        hold_cnt;
  int        total_items;
  int        results_seen;
  bit        hold_done;
  bit        failed;

  cramer_3x3_solver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // 3x3 determinant by the rule of Sarrus; exact in 64 bits for 16-bit inputs.
  function automatic longint det3x3(input longint m[9]);
    return m[0] * m[4] * m[8] + m[1] * m[5] * m[6] + m[2] * m[3] * m[7]
         - m[6] * m[4] * m[2] - m[7] * m[5] * m[0] - m[8] * m[3] * m[1];
  endfunction

  // num/den as Q16.16, truncated toward zero, clipped to 32 bits.
  // An integer part of 2^15 or more counts as a clip even when the negative
  // limit would hold it exactly.
  function automatic logic [c3s_pkg::QW-1:0] quotient_q16(input longint num,
                                                          input longint den,
                                                          inout bit sat);
    bit          neg;
    logic [63:0] n, d, ip, q, lim;
    neg = ((num < 0) != (den < 0)) && (num != 0);
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    ip  = n / d;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (ip >= 64'h8000) begin
      sat = 1'b1;
      q   = lim;
    end else begin
      q = (n << c3s_pkg::SOL_FRAC) / d;  // n < 2^48, so the shift cannot overflow
      if (q > lim) begin
        sat = 1'b1;
        q   = lim;
      end
    end
    if (neg) q = -q;
    return q[c3s_pkg::QW-1:0];
  endfunction

  function automatic solution_t solve_system(input c3s_pkg::sys_t s);
    solution_t r;
    longint    a[12];
    longint    m[9];
    longint    det;
    longint    dcol[3];
    logic [c3s_pkg::QW-1:0] sol[3];
    bit        sat;
    for (int i = 0; i < 12; i++) a[i] = longint'(signed'(s[i]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i*3+j] = a[i*4+j];
    det = det3x3(m);
    // replace one column at a time with the right-hand sides
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i*3+j] = (j == c) ? a[i*4+3] : a[i*4+j];
      dcol[c] = det3x3(m);
    end
    sat = 1'b0;
    if (det == 0) begin
      for (int c = 0; c < 3; c++) sol[c] = '0;
    end else begin
      for (int c = 0; c < 3; c++) sol[c] = quotient_q16(dcol[c], det, sat);
    end
    r.x         = sol[0];
    r.y         = sol[1];
    r.z         = sol[2];
    r.det       = det[c3s_pkg::DW-1:0];
    r.singular  = (det == 0);
    r.saturated = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued systems, idles in random bursts except near the end
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      gap_cnt   <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_solutions.push_back(solve_system(cur_sys));
      if (in_tvalid && !in_tready) begin
        // transaction still waiting: hold valid and data
      end else if (gap_cnt > 0) begin
        gap_cnt   <= gap_cnt - 1;
        in_tvalid <= 1'b0;
      end else if (pending_systems.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_systems.size() > 40 && $urandom_range(0, 7) == 0) begin
        gap_cnt   <= $urandom_range(0, 9);
        in_tvalid <= 1'b0;
      end else begin
        cur_sys   = pending_systems.pop_front();
        in_tdata  <= cur_sys;
        in_tvalid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, one long hold-off, field-by-field checks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    solution_t e;
    logic [c3s_pkg::QW-1:0] ax, ay, az;
    logic [c3s_pkg::DW-1:0] adet;
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stall_cnt    <= 0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        ax   = out_tdata[c3s_pkg::QW-1:0];
        ay   = out_tdata[2*c3s_pkg::QW-1:c3s_pkg::QW];
        az   = out_tdata[3*c3s_pkg::QW-1:2*c3s_pkg::QW];
        adet = out_tdata[3*c3s_pkg::QW+c3s_pkg::DW-1:3*c3s_pkg::QW];
        if (expected_solutions.size() == 0) begin
          $display("%0t: result with nothing expected, sol_x %h", $time, ax);
          failed = 1'b1;
        end else begin
          e = expected_solutions.pop_front();
          if (ax !== e.x) begin
            $display("%0t: sol_x expected %h actual %h", $time, e.x, ax);
            failed = 1'b1;
          end
          if (ay !== e.y) begin
            $display("%0t: sol_y expected %h actual %h", $time, e.y, ay);
            failed = 1'b1;
          end
          if (az !== e.z) begin
            $display("%0t: sol_z expected %h actual %h", $time, e.z, az);
            failed = 1'b1;
          end
          if (adet !== e.det) begin
            $display("%0t: main_det expected %h actual %h", $time, e.det, adet);
            failed = 1'b1;
          end
          if (out_tuser[0] !== e.singular) begin
            $display("%0t: singular expected %b actual %b", $time, e.singular, out_tuser[0]);
            failed = 1'b1;
          end
          if (out_tuser[1] !== e.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                     out_tuser[1]);
            failed = 1'b1;
          end
        end
      end
      if (hold_cnt > 0) begin
        // long hold-off: the pipeline fills and in_tready must drop
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done  <= 1'b1;
        hold_cnt   <= 200;
        out_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt  <= stall_cnt - 1;
        out_tready <= 1'b0;
      end else if (results_seen < total_items - 40 && $urandom_range(0, 7) == 0) begin
        stall_cnt  <= $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_system(input int r0x, r0y, r0z, r0b, r1x, r1y, r1z, r1b,
                            input int r2x, r2y, r2z, r2b);
    c3s_pkg::sys_t s;
    s[0] = c3s_pkg::CW'(r0x); s[1] = c3s_pkg::CW'(r0y);
    s[2] = c3s_pkg::CW'(r0z); s[3] = c3s_pkg::CW'(r0b);
    s[4] = c3s_pkg::CW'(r1x); s[5] = c3s_pkg::CW'(r1y);
    s[6] = c3s_pkg::CW'(r1z); s[7] = c3s_pkg::CW'(r1b);
    s[8] = c3s_pkg::CW'(r2x); s[9] = c3s_pkg::CW'(r2y);
    s[10] = c3s_pkg::CW'(r2z); s[11] = c3s_pkg::CW'(r2b);
    pending_systems.push_back(s);
  endtask

  function automatic int rnd_coef(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  initial begin
    c3s_pkg::sys_t s;
    int   kind;
    failed      = 1'b0;
    total_items = 420;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;

    // directed systems
    add_system(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                   // all zero, singular
    add_system(256, 0, 0, 256, 0, 256, 0, 512, 0, 0, 256, -768);      // identity
    add_system(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
               32767, 32767, 32767, 32767);                           // all max, singular
    add_system(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
               -32768, -32768, -32768, -32768);                       // all min, singular
    add_system(-32768, 0, 0, 32767, 0, -32768, 0, -32768, 0, 0, -32768, 32767);
    add_system(1, 0, 0, 32767, 0, 1, 0, -32768, 0, 0, 1, 1);          // tiny det, big quotients
    add_system(1, 0, 0, -32768, 0, 1, 0, 0, 0, 0, 1, -1);             // integer part exactly 2^15
    add_system(1, 32767, 0, 0, 0, 1, 0, 32767, 0, 0, 1, 0);           // negative clip
    add_system(1, 32767, 0, 0, 0, 1, 0, -32767, 0, 0, 1, 0);          // positive clip
    add_system(0, 0, -256, 100, 256, 0, 0, -100, 0, 512, 0, 7);       // permutation, signs
    add_system(32767, -32768, 0, 32767, -32768, 32767, 0, -32768, 0, 0, 32767, 32767);
    add_system(256, 256, 256, 0, 256, 256, 256, 0, 1, 2, 3, 0);        // dependent rows
    add_system(3, 1, 1, 5, 1, 3, 1, 5, 1, 1, 3, 5);
    add_system(-1, 0, 0, 1, 0, -1, 0, 1, 0, 0, -1, 1);
    for (int i = 0; i < 6; i++) begin
      for (int f = 0; f < 12; f++) s[f] = c3s_pkg::CW'($urandom);
      pending_systems.push_back(s);
    end

    // random systems: full range, small well-conditioned, singular, near-singular
    while (pending_systems.size() < total_items) begin
      kind = $urandom_range(0, 9);
      for (int f = 0; f < 12; f++) begin
        if (kind < 4) s[f] = c3s_pkg::CW'($urandom);
        else s[f] = c3s_pkg::CW'(rnd_coef(-1024, 1024));
      end
      if (kind == 7) begin
        for (int f = 0; f < 4; f++) s[8+f] = s[f];              // repeated equation
      end else if (kind >= 8) begin
        for (int f = 0; f < 12; f++)
          if (f % 4 != 3) s[f] = (f % 5 == 0) ? c3s_pkg::CW'(rnd_coef(-3, 3))
                                              : c3s_pkg::CW'(rnd_coef(-1, 1));
          else s[f] = c3s_pkg::CW'($urandom);                    // small det, wide rhs
      end
      pending_systems.push_back(s);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_systems.size() != 0 || in_tvalid || expected_solutions.size() != 0)
      @(posedge clk);
    repeat (c3s_pkg::LAT + 10) @(posedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
